// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    // address and page geometry
    localparam int ADDR_W            = 24;
    localparam int PAGE_BYTES        = 256;
    localparam int BUF_AW            = $clog2(PAGE_BYTES);
    localparam int MEM_BYTES_DEFAULT = 262144;

    localparam logic [BUF_AW:0] BUF_FULL  = (BUF_AW + 1)'(PAGE_BYTES);
    localparam logic [15:0] PAGE_LAST_CNT = 16'(PAGE_BYTES - 1);
    localparam logic [15:0] SECTOR_LAST_CNT = 16'hffff;

    // command codes
    localparam logic [7:0] CMD_NONE        = 8'h00;
    localparam logic [7:0] CMD_READ_ID     = 8'h9f;
    localparam logic [7:0] CMD_POWER_DOWN  = 8'hb9;
    localparam logic [7:0] CMD_WRITE_EN    = 8'h06;
    localparam logic [7:0] CMD_WRITE_DIS   = 8'h04;
    localparam logic [7:0] CMD_PAGE_ERASE  = 8'hdb;
    localparam logic [7:0] CMD_SECT_ERASE  = 8'hd8;
    localparam logic [7:0] CMD_PAGE_WRITE  = 8'h02;
    localparam logic [7:0] CMD_PAGE_MODIFY = 8'h0a;
    localparam logic [7:0] CMD_READ        = 8'h03;
    localparam logic [7:0] CMD_FAST_READ   = 8'h0b;
    localparam logic [7:0] CMD_WAKE        = 8'hab;
    localparam logic [7:0] CMD_READ_STATUS = 8'h05;

    // status register bit for write enable
    localparam logic [7:0] STATUS_WEL = 8'h02;
    localparam logic [7:0] ERASED     = 8'hff;

    // request to the shared address unit
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              fix_range;  // restart at zero when beyond memory
        logic              wrap_page;  // step within the page
    } addr_req_t;

    // answer of the shared address unit
    typedef struct packed {
        logic              in_range;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] next;
    } addr_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/spi_serial_flash_device.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  payload
// cfg_*     in         cfg_data[23:0] = device_id
// s_*       in         s_tdata[7:0] = mosi_byte, s_tuser[0] = opcode (1 = deselect)
// m_*       out        m_tdata[7:0] = miso_byte
//
// an accepted byte goes from S_EXEC (and S_RDDATA when the array is read) to S_RESP;
// the sequencer handles one transaction at a time and the result waits in an output register.
// on deselect with write enable set, program walks the page through S_PROG_RD and S_PROG_WR
// per byte, modify adds a fill through S_FILL_RD and S_FILL_WR and a page erase, and sector
// erase writes one byte per cycle (65536 bytes). after reset the array is swept to 0xff one
// byte per cycle with s_tready low; configuration writes are taken at any time.

module spi_serial_flash_device #(
    parameter int MEM_BYTES = sfd_pkg::MEM_BYTES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] mosi_byte
    input  wire logic [0:0]  s_tuser,   // [0] opcode
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [7:0] miso_byte
);

    import sfd_pkg::*;

    localparam int FLASH_AW = $clog2(MEM_BYTES);

    logic [23:0]         device_id_reg;
    addr_req_t           au_req;
    addr_rsp_t           au_rsp;
    logic                flash_we;
    logic [FLASH_AW-1:0] flash_addr;
    logic [7:0]          flash_wdata;
    logic [7:0]          flash_rdata;
    logic                buf_we;
    logic [BUF_AW-1:0]   buf_addr;
    logic [7:0]          buf_wdata;
    logic [7:0]          buf_rdata;

    // identification register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_id_reg <= '0;
        end else if (cfg_valid) begin
            device_id_reg <= cfg_data;
        end
    end

    sfd_ctrl #(
        .MEM_BYTES (MEM_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .device_id   (device_id_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser[0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .au_req      (au_req),
        .au_rsp      (au_rsp),
        .flash_we    (flash_we),
        .flash_addr  (flash_addr),
        .flash_wdata (flash_wdata),
        .flash_rdata (flash_rdata),
        .buf_we      (buf_we),
        .buf_addr    (buf_addr),
        .buf_wdata   (buf_wdata),
        .buf_rdata   (buf_rdata)
    );

    sfd_addr_unit #(
        .MEM_BYTES (MEM_BYTES)
    ) u_addr_unit (
        .req (au_req),
        .rsp (au_rsp)
    );

    // flash array
    sfd_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_flash_ram (
        .clk   (aclk),
        .we    (flash_we),
        .addr  (flash_addr),
        .wdata (flash_wdata),
        .rdata (flash_rdata)
    );

    // page buffer
    sfd_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_page_buf (
        .clk   (aclk),
        .we    (buf_we),
        .addr  (buf_addr),
        .wdata (buf_wdata),
        .rdata (buf_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/sfd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/sfd_addr_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfd_addr_unit #(
    parameter int MEM_BYTES = sfd_pkg::MEM_BYTES_DEFAULT
) (
    input  wire sfd_pkg::addr_req_t req,
    output sfd_pkg::addr_rsp_t      rsp
);

    import sfd_pkg::*;

    localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W + 1)'(MEM_BYTES);

    logic              in_range;
    logic [ADDR_W-1:0] base;

    // range check, optional restart at zero, then one step forward
    always_comb begin
        in_range = ({1'b0, req.addr} < MEM_LIMIT);
        base     = (req.fix_range && !in_range) ? '0 : req.addr;
        rsp.in_range = in_range;
        rsp.base     = base;
        if (req.wrap_page) begin
            rsp.next = {base[ADDR_W-1:BUF_AW], base[BUF_AW-1:0] + 1'b1};
        end else begin
            rsp.next = base + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfd_ctrl #(
    parameter int MEM_BYTES = sfd_pkg::MEM_BYTES_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [23:0]                  device_id,
    // input transactions
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,
    input  wire logic                         s_tuser,
    // result transactions
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [7:0]                        m_tdata,
    // shared address unit
    output sfd_pkg::addr_req_t                au_req,
    input  wire sfd_pkg::addr_rsp_t           au_rsp,
    // flash array port
    output logic                              flash_we,
    output logic [$clog2(MEM_BYTES)-1:0]      flash_addr,
    output logic [7:0]                        flash_wdata,
    input  wire logic [7:0]                   flash_rdata,
    // page buffer port
    output logic                              buf_we,
    output logic [sfd_pkg::BUF_AW-1:0]        buf_addr,
    output logic [7:0]                        buf_wdata,
    input  wire logic [7:0]                   buf_rdata
);

    import sfd_pkg::*;

    localparam int FLASH_AW = $clog2(MEM_BYTES);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_EXEC    = 10'b00_0000_0100,
        S_RDDATA  = 10'b00_0000_1000,
        S_FILL_RD = 10'b00_0001_0000,
        S_FILL_WR = 10'b00_0010_0000,
        S_ERASE   = 10'b00_0100_0000,
        S_PROG_RD = 10'b00_1000_0000,
        S_PROG_WR = 10'b01_0000_0000,
        S_RESP    = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [BUF_AW:0]   bf_reg, bf_next;
    logic [1:0]        abl_reg, abl_next;
    logic [ADDR_W-1:0] bp_reg, bp_next;
    logic [ADDR_W-1:0] ps_reg, ps_next;
    logic              pw_reg, pw_next;
    logic              we_reg, we_next;
    logic [ADDR_W-1:0] walk_reg, walk_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic              op_reg, op_next;
    logic [7:0]        din_reg, din_next;
    logic [7:0]        res_reg, res_next;
    logic              mv_reg, mv_next;
    logic [7:0]        md_reg, md_next;

    logic              is_write_cmd;
    logic              out_free;
    logic [ADDR_W-1:0] erase_base;
    logic [15:0]       erase_cnt;
    logic [ADDR_W-1:0] flash_sel;
    logic [BUF_AW:0]   bf_dec;
    logic              powered_eff;
    logic [7:0]        prog_val;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign out_free = !mv_reg || m_tready;

    assign is_write_cmd = (cmd_reg == CMD_PAGE_WRITE) || (cmd_reg == CMD_PAGE_MODIFY);
    assign flash_addr   = flash_sel[FLASH_AW-1:0];
    assign bf_dec       = (bf_reg != '0) ? bf_reg - 1'b1 : bf_reg;
    assign powered_eff  = pw_reg || (din_reg == CMD_WAKE);
    assign prog_val     = ({1'b0, cnt_reg[BUF_AW-1:0]} < bf_reg) ? buf_rdata : ERASED;

    // erase block start and length, page or 64 KiB sector
    always_comb begin
        if (cmd_reg == CMD_SECT_ERASE) begin
            erase_base = {ps_reg[ADDR_W-1:16], 16'h0000};
            erase_cnt  = SECTOR_LAST_CNT;
        end else begin
            erase_base = {ps_reg[ADDR_W-1:BUF_AW], {BUF_AW{1'b0}}};
            erase_cnt  = PAGE_LAST_CNT;
        end
    end

    // request mux for the shared address unit
    always_comb begin
        au_req.addr      = walk_reg;
        au_req.fix_range = 1'b0;
        au_req.wrap_page = 1'b0;
        case (state_reg)
            S_EXEC: begin
                au_req.addr      = bp_reg;
                au_req.fix_range = 1'b1;
                au_req.wrap_page = is_write_cmd;
            end
            S_FILL_RD: begin
                au_req.addr      = bp_reg;
                au_req.fix_range = 1'b1;
                au_req.wrap_page = 1'b1;
            end
            S_PROG_WR: begin
                au_req.wrap_page = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        bf_next     = bf_reg;
        abl_next    = abl_reg;
        bp_next     = bp_reg;
        ps_next     = ps_reg;
        pw_next     = pw_reg;
        we_next     = we_reg;
        walk_next   = walk_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        din_next    = din_reg;
        res_next    = res_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        flash_sel   = walk_reg;
        flash_we    = 1'b0;
        flash_wdata = ERASED;
        buf_we      = 1'b0;
        buf_addr    = bf_reg[BUF_AW-1:0];
        buf_wdata   = din_reg;

        case (state_reg)
            // fill the array with the erased value after reset
            S_CLEAR: begin
                if (au_rsp.in_range) begin
                    flash_we  = 1'b1;
                    walk_next = au_rsp.next;
                    // the largest array ends at the top of the address space
                    if (walk_reg == {ADDR_W{1'b1}}) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    din_next   = s_tdata;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                res_next   = 8'h00;
                state_next = S_RESP;
                flash_sel  = au_rsp.base;
                if (op_reg) begin
                    // chip select released: finish pending operations
                    if (cmd_reg != CMD_NONE && we_reg) begin
                        case (cmd_reg)
                            CMD_PAGE_MODIFY: begin
                                if (bf_reg < BUF_FULL) begin
                                    state_next = S_FILL_RD;
                                end else begin
                                    walk_next  = erase_base;
                                    cnt_next   = erase_cnt;
                                    state_next = S_ERASE;
                                end
                            end
                            CMD_PAGE_ERASE, CMD_SECT_ERASE: begin
                                walk_next  = erase_base;
                                cnt_next   = erase_cnt;
                                state_next = S_ERASE;
                            end
                            CMD_PAGE_WRITE: begin
                                walk_next  = ps_reg;
                                cnt_next   = '0;
                                state_next = S_PROG_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end else if (cmd_reg == CMD_NONE) begin
                    // command byte
                    cmd_next = din_reg;
                    bf_next  = '0;
                    bp_next  = '0;
                    abl_next = '0;
                    if (din_reg == CMD_WAKE) begin
                        pw_next = 1'b1;
                    end
                    if (powered_eff) begin
                        if (din_reg == CMD_READ_ID) begin
                            bf_next = (BUF_AW + 1)'(3);
                        end
                        if (din_reg == CMD_POWER_DOWN) begin
                            pw_next = 1'b0;
                        end
                        if (din_reg == CMD_WRITE_EN) begin
                            we_next = 1'b1;
                        end
                        if (din_reg == CMD_WRITE_DIS) begin
                            we_next = 1'b0;
                        end
                        if (din_reg inside {CMD_PAGE_ERASE, CMD_SECT_ERASE, CMD_PAGE_WRITE,
                                            CMD_PAGE_MODIFY, CMD_READ, CMD_FAST_READ}) begin
                            abl_next = 2'd3;
                        end
                    end
                end else if (!pw_reg) begin
                    res_next = 8'h00;
                end else if (abl_reg != 2'd0) begin
                    // address byte, most significant first
                    abl_next = abl_reg - 2'd1;
                    bp_next  = {bp_reg[ADDR_W-9:0], din_reg};
                    ps_next  = {bp_reg[ADDR_W-9:0], din_reg};
                    if (cmd_reg == CMD_FAST_READ) begin
                        bf_next = (BUF_AW + 1)'(1);
                    end
                end else begin
                    case (cmd_reg)
                        CMD_READ_ID: begin
                            bf_next = bf_dec;
                            case (bf_dec)
                                (BUF_AW + 1)'(0): res_next = device_id[7:0];
                                (BUF_AW + 1)'(1): res_next = device_id[15:8];
                                (BUF_AW + 1)'(2): res_next = device_id[23:16];
                                default:          res_next = 8'h00;
                            endcase
                        end
                        CMD_READ_STATUS: begin
                            res_next = we_reg ? STATUS_WEL : 8'h00;
                        end
                        CMD_READ, CMD_FAST_READ: begin
                            if (bf_reg != '0) begin
                                bf_next = bf_reg - 1'b1;
                            end else begin
                                bp_next    = au_rsp.next;
                                state_next = S_RDDATA;
                            end
                        end
                        CMD_PAGE_WRITE, CMD_PAGE_MODIFY: begin
                            if (bf_reg < BUF_FULL) begin
                                buf_we     = 1'b1;
                                bf_next    = bf_reg + 1'b1;
                                bp_next    = au_rsp.next;
                                state_next = S_RDDATA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // old data from the array
            S_RDDATA: begin
                res_next   = flash_rdata;
                state_next = S_RESP;
            end

            // page modify: complete the buffer from the array
            S_FILL_RD: begin
                flash_sel  = au_rsp.base;
                bp_next    = au_rsp.next;
                state_next = S_FILL_WR;
            end

            S_FILL_WR: begin
                buf_we    = 1'b1;
                buf_wdata = flash_rdata;
                bf_next   = bf_reg + 1'b1;
                if (bf_reg + 1'b1 < BUF_FULL) begin
                    state_next = S_FILL_RD;
                end else begin
                    walk_next  = erase_base;
                    cnt_next   = erase_cnt;
                    state_next = S_ERASE;
                end
            end

            // one byte erased per cycle
            S_ERASE: begin
                flash_we  = au_rsp.in_range;
                walk_next = au_rsp.next;
                if (cnt_reg == '0) begin
                    we_next = 1'b0;
                    if (cmd_reg == CMD_PAGE_MODIFY) begin
                        walk_next  = ps_reg;
                        state_next = S_PROG_RD;
                    end else begin
                        state_next = S_RESP;
                    end
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            // program: read array and buffer, then write back the and
            S_PROG_RD: begin
                buf_addr   = cnt_reg[BUF_AW-1:0];
                state_next = S_PROG_WR;
            end

            S_PROG_WR: begin
                flash_we    = au_rsp.in_range;
                flash_wdata = flash_rdata & prog_val;
                walk_next   = au_rsp.next;
                buf_addr    = cnt_reg[BUF_AW-1:0];
                if (cnt_reg[BUF_AW-1:0] == {BUF_AW{1'b1}}) begin
                    we_next    = 1'b0;
                    state_next = S_RESP;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_PROG_RD;
                end
            end

            // hand the result to the output register
            S_RESP: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    md_next    = res_reg;
                    state_next = S_IDLE;
                    if (op_reg) begin
                        cmd_next = CMD_NONE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cmd_reg   <= CMD_NONE;
            bf_reg    <= '0;
            abl_reg   <= '0;
            bp_reg    <= '0;
            ps_reg    <= '0;
            pw_reg    <= 1'b1;
            we_reg    <= 1'b0;
            walk_reg  <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            bf_reg    <= bf_next;
            abl_reg   <= abl_next;
            bp_reg    <= bp_next;
            ps_reg    <= ps_next;
            pw_reg    <= pw_next;
            we_reg    <= we_next;
            walk_reg  <= walk_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        din_reg <= din_next;
        res_reg <= res_next;
        md_reg  <= md_next;
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sfd_pkg::*;

    localparam int          MEM_B       = MEM_BYTES_DEFAULT;
    localparam logic        OP_BYTE     = 1'b0;
    localparam logic        OP_DESELECT = 1'b1;
    localparam logic [23:0] DIR_ID      = 24'ha53c81;
    localparam int          RAND_ITEMS  = 1450;
    localparam int          DIR_N       = 31;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] mosi_byte
    logic [0:0]  s_tuser = '0;   // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] miso_byte

    // one stimulus row: opcode, byte sent, and a miso value typed in where obvious
    typedef struct packed {
        logic       op;
        logic [7:0] mosi;
        logic       typed;
        logic [7:0] miso;
    } dir_row_t;

    dir_row_t dir_rows [0:DIR_N-1] = '{
        '{OP_DESELECT, 8'hff, 1'b1, 8'h00},         // deselect while idle
        '{OP_BYTE, CMD_NONE, 1'b1, 8'h00},          // zero command keeps waiting
        '{OP_BYTE, CMD_READ_ID, 1'b1, 8'h00},
        '{OP_BYTE, 8'hff, 1'b1, DIR_ID[23:16]},
        '{OP_BYTE, 8'h00, 1'b1, DIR_ID[15:8]},
        '{OP_BYTE, 8'h5a, 1'b1, DIR_ID[7:0]},
        '{OP_BYTE, 8'h33, 1'b1, DIR_ID[7:0]},       // low id byte repeats
        '{OP_DESELECT, 8'h00, 1'b1, 8'h00},
        '{OP_BYTE, CMD_WRITE_EN, 1'b1, 8'h00},
        '{OP_DESELECT, 8'h5a, 1'b1, 8'h00},
        '{OP_BYTE, CMD_READ_STATUS, 1'b1, 8'h00},
        '{OP_BYTE, 8'hc3, 1'b1, STATUS_WEL},
        '{OP_DESELECT, 8'h00, 1'b1, 8'h00},
        '{OP_BYTE, CMD_WRITE_DIS, 1'b1, 8'h00},
        '{OP_DESELECT, 8'h00, 1'b1, 8'h00},
        '{OP_BYTE, CMD_WRITE_EN, 1'b1, 8'h00},
        '{OP_DESELECT, 8'h00, 1'b1, 8'h00},
        // page write addressed past the array: pointer restarts, program skipped
        '{OP_BYTE, CMD_PAGE_WRITE, 1'b1, 8'h00},
        '{OP_BYTE, 8'hff, 1'b1, 8'h00},
        '{OP_BYTE, 8'hff, 1'b1, 8'h00},
        '{OP_BYTE, 8'hf0, 1'b1, 8'h00},
        '{OP_BYTE, 8'h00, 1'b0, 8'h00},
        '{OP_DESELECT, 8'h00, 1'b1, 8'h00},
        // powered down: data bytes read zero until wake
        '{OP_BYTE, CMD_POWER_DOWN, 1'b1, 8'h00},
        '{OP_BYTE, 8'h55, 1'b1, 8'h00},
        '{OP_DESELECT, 8'h00, 1'b1, 8'h00},
        '{OP_BYTE, CMD_READ_ID, 1'b1, 8'h00},
        '{OP_BYTE, 8'haa, 1'b1, 8'h00},
        '{OP_DESELECT, 8'h00, 1'b1, 8'h00},
        '{OP_BYTE, CMD_WAKE, 1'b1, 8'h00},
        '{OP_DESELECT, 8'h00, 1'b1, 8'h00}
    };

    // flash image and command state kept by the testbench
    logic [7:0]  flash_img [0:MEM_B-1];
    logic [7:0]  page_buf [0:PAGE_BYTES-1];
    int unsigned buf_fill;
    logic [7:0]  active_cmd;
    int unsigned addr_left;
    logic [23:0] byte_ptr;
    logic [23:0] page_base;
    bit          powered;
    bit          wr_enabled;
    logic [23:0] id_value;

    logic [7:0]  miso_expected [$];
    logic [7:0]  seq_bytes [$];
    logic [7:0]  miso_want;
    int          mismatches = 0;
    int          items_sent = 0;
    int          sector_budget = 2;
    int          long_budget = 2;
    bit          calm = 1'b0;
    bit          hold_kick = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    spi_serial_flash_device #(
        .MEM_BYTES(MEM_B)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------- flash behaviour

    function automatic void flash_reset();
        foreach (flash_img[i]) flash_img[i] = ERASED;
        foreach (page_buf[i]) page_buf[i] = 8'h00;
        buf_fill   = 0;
        active_cmd = CMD_NONE;
        addr_left  = 0;
        byte_ptr   = '0;
        page_base  = '0;
        powered    = 1'b1;
        wr_enabled = 1'b0;
        id_value   = '0;
    endfunction

    // step within the page, keeping the page bits
    function automatic logic [23:0] page_step(logic [23:0] a);
        return {a[23:8], 8'(a[7:0] + 8'd1)};
    endfunction

    function automatic void erase_region(int unsigned block);
        logic [23:0] base;
        logic [23:0] p;
        base = page_base & ~24'(block - 1);
        for (int unsigned n = 0; n < block; n++) begin
            p = 24'(base + n);
            if (p < MEM_B) flash_img[p] = ERASED;
        end
    endfunction

    // deselect with write enabled: finish erase and program
    function automatic void complete_command();
        logic [23:0] a;
        logic [7:0]  v;
        if (active_cmd == CMD_PAGE_MODIFY) begin
            while (buf_fill < PAGE_BYTES) begin
                if (byte_ptr >= MEM_B) byte_ptr = '0;
                page_buf[buf_fill] = flash_img[byte_ptr];
                buf_fill++;
                byte_ptr = page_step(byte_ptr);
            end
        end
        if (active_cmd == CMD_PAGE_MODIFY || active_cmd == CMD_PAGE_ERASE ||
            active_cmd == CMD_SECT_ERASE) begin
            erase_region(active_cmd == CMD_SECT_ERASE ? 65536 : PAGE_BYTES);
            wr_enabled = 1'b0;
        end
        if (active_cmd == CMD_PAGE_MODIFY || active_cmd == CMD_PAGE_WRITE) begin
            a = page_base;
            for (int unsigned n = 0; n < PAGE_BYTES; n++) begin
                v = (n < buf_fill) ? page_buf[n] : ERASED;
                if (a < MEM_B) flash_img[a] = flash_img[a] & v;
                a = page_step(a);
            end
            wr_enabled = 1'b0;
        end
    endfunction

    function automatic logic [7:0] exchange_byte(logic [7:0] d);
        logic [7:0] r;
        // first byte after deselect is the command
        if (active_cmd == CMD_NONE) begin
            active_cmd = d;
            buf_fill   = 0;
            byte_ptr   = '0;
            addr_left  = 0;
            if (d == CMD_WAKE) powered = 1'b1;
            if (powered) begin
                case (d)
                    CMD_READ_ID:    buf_fill = 3;
                    CMD_POWER_DOWN: powered = 1'b0;
                    CMD_WRITE_EN:   wr_enabled = 1'b1;
                    CMD_WRITE_DIS:  wr_enabled = 1'b0;
                    CMD_PAGE_ERASE, CMD_SECT_ERASE, CMD_PAGE_WRITE, CMD_PAGE_MODIFY,
                    CMD_READ, CMD_FAST_READ: addr_left = 3;
                    default: ;
                endcase
            end
            return 8'h00;
        end
        if (!powered) return 8'h00;
        // address bytes, most significant first
        if (addr_left != 0) begin
            addr_left--;
            byte_ptr  = {byte_ptr[15:0], d};
            page_base = byte_ptr;
            if (active_cmd == CMD_FAST_READ) buf_fill = 1;
            return 8'h00;
        end
        case (active_cmd)
            CMD_READ_ID: begin
                if (buf_fill != 0) buf_fill--;
                if (buf_fill < 3) return 8'(id_value >> (8 * buf_fill));
                return 8'h00;
            end
            CMD_READ_STATUS: return wr_enabled ? STATUS_WEL : 8'h00;
            CMD_READ, CMD_FAST_READ: begin
                if (buf_fill != 0) begin
                    buf_fill--;
                    return 8'h00;
                end
                if (byte_ptr >= MEM_B) byte_ptr = '0;
                r = flash_img[byte_ptr];
                byte_ptr = byte_ptr + 24'd1;
                return r;
            end
            CMD_PAGE_WRITE, CMD_PAGE_MODIFY: begin
                if (buf_fill < PAGE_BYTES) begin
                    if (byte_ptr >= MEM_B) byte_ptr = '0;
                    page_buf[buf_fill] = d;
                    buf_fill++;
                    r = flash_img[byte_ptr];
                    byte_ptr = page_step(byte_ptr);
                    return r;
                end
                return 8'h00;
            end
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] predict_miso(logic op, logic [7:0] d);
        if (op == OP_DESELECT) begin
            if (active_cmd != CMD_NONE && wr_enabled) complete_command();
            active_cmd = CMD_NONE;
            return 8'h00;
        end
        return exchange_byte(d);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // data biased towards all zeros and all ones
    function automatic logic [7:0] data_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return rand_byte();
        endcase
    endfunction

    // mostly a few hot pages, sometimes the top page or past the array
    function automatic logic [23:0] pick_addr();
        logic [7:0] pg;
        logic [7:0] offs;
        offs = $urandom_range(0, 1) ? rand_byte() : 8'($urandom_range(240, 255));
        case ($urandom_range(0, 9))
            0: return 24'($urandom());
            1: return 24'(MEM_B - PAGE_BYTES) + 24'(offs);
            2: return {8'($urandom_range(4, 255)), rand_byte(), rand_byte()};
            default: begin
                case ($urandom_range(0, 3))
                    0:       pg = 8'h00;
                    1:       pg = 8'h01;
                    2:       pg = 8'h80;
                    default: pg = 8'hff;
                endcase
                return {6'd0, 2'($urandom_range(0, 3)), pg, offs};
            end
        endcase
    endfunction

    function automatic void push_addr(logic [23:0] a);
        seq_bytes.push_back(a[23:16]);
        seq_bytes.push_back(a[15:8]);
        seq_bytes.push_back(a[7:0]);
    endfunction

    // a random command byte that never starts a sector erase
    function automatic logic [7:0] noise_cmd();
        logic [7:0] c;
        c = rand_byte();
        return (c == CMD_SECT_ERASE) ? CMD_PAGE_ERASE : c;
    endfunction

    // offer one transaction and record its expected miso byte once accepted
    task automatic put(input logic op, input logic [7:0] d,
                       input bit typed = 1'b0, input logic [7:0] typed_miso = 8'h00);
        logic [7:0] want;
        while (!calm && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_miso(op, d);
        miso_expected.push_back(typed ? typed_miso : want);
        items_sent++;
    endtask

    task automatic deselect();
        put(OP_DESELECT, rand_byte());
    endtask

    task automatic command_alone(input logic [7:0] c);
        put(OP_BYTE, c);
        deselect();
    endtask

    // input released, then wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (miso_expected.size() != 0);
    endtask

    task automatic write_device_id(input logic [23:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        id_value = v;
        cfg_valid <= 1'b0;
    endtask

    // one chip-select run: mostly well formed, sometimes cut short or noise
    task automatic run_sequence();
        int kind;
        int n;
        int cut;
        bit arm;
        kind = $urandom_range(0, 99);
        arm  = ($urandom_range(0, 4) != 0);
        seq_bytes.delete();
        if (!powered && $urandom_range(0, 3) != 0) command_alone(CMD_WAKE);
        if (kind < 8) begin
            seq_bytes.push_back(CMD_READ_ID);
            repeat ($urandom_range(1, 5)) seq_bytes.push_back(rand_byte());
        end else if (kind < 14) begin
            seq_bytes.push_back(CMD_READ_STATUS);
            repeat ($urandom_range(1, 3)) seq_bytes.push_back(rand_byte());
        end else if (kind < 17) begin
            seq_bytes.push_back(CMD_WRITE_EN);
        end else if (kind < 20) begin
            seq_bytes.push_back(CMD_WRITE_DIS);
        end else if (kind < 38) begin
            seq_bytes.push_back(CMD_READ);
            push_addr(pick_addr());
            repeat ($urandom_range(1, 16)) seq_bytes.push_back(rand_byte());
        end else if (kind < 48) begin
            seq_bytes.push_back(CMD_FAST_READ);
            push_addr(pick_addr());
            repeat ($urandom_range(1, 14)) seq_bytes.push_back(rand_byte());
        end else if (kind < 78) begin
            // page write or page modify, occasionally past a full buffer
            if (arm) command_alone(CMD_WRITE_EN);
            seq_bytes.push_back(kind < 66 ? CMD_PAGE_WRITE : CMD_PAGE_MODIFY);
            push_addr(pick_addr());
            n = $urandom_range(1, 24);
            if (long_budget > 0 && $urandom_range(0, 24) == 0) begin
                long_budget--;
                n = $urandom_range(PAGE_BYTES, PAGE_BYTES + 16);
            end
            repeat (n) seq_bytes.push_back(data_byte());
        end else if (kind < 86) begin
            if (arm) command_alone(CMD_WRITE_EN);
            seq_bytes.push_back(CMD_PAGE_ERASE);
            push_addr(pick_addr());
            repeat ($urandom_range(0, 2)) seq_bytes.push_back(rand_byte());
        end else if (kind < 88) begin
            // sector erase is slow: only a couple of them really run
            if (arm && sector_budget > 0) begin
                sector_budget--;
                command_alone(CMD_WRITE_EN);
            end else begin
                command_alone(CMD_WAKE);
                command_alone(CMD_WRITE_DIS);
            end
            seq_bytes.push_back(CMD_SECT_ERASE);
            push_addr(pick_addr());
        end else if (kind < 92) begin
            // power down, some ignored traffic, then wake
            command_alone(CMD_POWER_DOWN);
            put(OP_BYTE, noise_cmd());
            repeat ($urandom_range(0, 4)) put(OP_BYTE, rand_byte());
            deselect();
            seq_bytes.push_back(CMD_WAKE);
        end else begin
            // noise with stray deselects
            seq_bytes.push_back(noise_cmd());
            repeat ($urandom_range(0, 6)) seq_bytes.push_back(rand_byte());
        end
        // broken run: cut short before its end
        if (seq_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, seq_bytes.size() - 1);
            seq_bytes = seq_bytes[0:cut-1];
        end
        foreach (seq_bytes[i]) begin
            if (kind >= 92 && $urandom_range(0, 5) == 0) deselect();
            put(OP_BYTE, seq_bytes[i]);
        end
        deselect();
    endtask

    // ---------------------------------------------------------------- result side

    // receiver: random stalls, one long hold-off, calm stretch
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_kick && !hold_done) begin
            hold_left <= 500;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 18);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (miso_expected.size() == 0) begin
                $display("%0t: unexpected miso_byte: expected none, actual %02h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                miso_want = miso_expected.pop_front();
                if (m_tdata !== miso_want) begin
                    $display("%0t: miso_byte mismatch: expected %02h, actual %02h",
                             $time, miso_want, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence of the run

    initial begin
        flash_reset();
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        write_device_id(DIR_ID);

        // directed rows
        foreach (dir_rows[i])
            put(dir_rows[i].op, dir_rows[i].mosi, dir_rows[i].typed, dir_rows[i].miso);

        // random phases, each with its own device id
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0:       write_device_id(24'h000000);
                1:       write_device_id(24'hffffff);
                default: write_device_id(24'($urandom()));
            endcase
            calm <= (ph == 2);
            if (ph == 1) hold_kick <= 1'b1;
            while (items_sent < DIR_N + (ph + 1) * RAND_ITEMS / 4) run_sequence();
        end

        drain_results();
        repeat (2000) @(posedge aclk);
        if (mismatches == 0 && miso_expected.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
